### hdl/thfc_pkg.sv
// ----------------------------------------------------------------------------
// thfc_pkg
// Shared types, format codes and constants of the tape header format
// classifier.
// ----------------------------------------------------------------------------
package thfc_pkg;

	// header position counter width, enough for the longest header
	localparam int unsigned POS_W = 7;
	localparam int unsigned COMMENT_BYTES_DEF = 104;

	// item kinds
	localparam logic KIND_LEADER = 1'b0;
	localparam logic KIND_HEADER = 1'b1;

	// tape format codes
	typedef enum logic [3:0] {
		FMT_UNKNOWN = 4'd0,
		FMT_DIRECT  = 4'd1,
		FMT_NORMAL  = 4'd2,
		FMT_ZX      = 4'd3,
		FMT_FASTIPL = 4'd4,
		FMT_TURBO   = 4'd5,
		FMT_FSK     = 4'd6,
		FMT_SLOW    = 4'd7,
		FMT_BSD     = 4'd8,
		FMT_CPM     = 4'd9
	} fmt_t;

	// input transaction
	typedef struct packed {
		logic        kind;
		logic [15:0] leader_period;
		logic [7:0]  header_byte;
	} item_t;

	// result transaction
	typedef struct packed {
		fmt_t tape_format;
		logic from_header;
	} result_t;

	// header layout
	localparam logic [POS_W-1:0] POS_TYPE     = 7'd0;
	localparam logic [POS_W-1:0] POS_SIZE_LO  = 7'd18;
	localparam logic [POS_W-1:0] POS_SIZE_HI  = 7'd19;
	localparam logic [POS_W-1:0] POS_START_LO = 7'd20;
	localparam logic [POS_W-1:0] POS_START_HI = 7'd21;
	localparam logic [POS_W-1:0] POS_EXEC_LO  = 7'd22;
	localparam logic [POS_W-1:0] POS_EXEC_HI  = 7'd23;
	localparam logic [POS_W-1:0] POS_COMMENT  = 7'd24;

	// comment offsets of the loader fields
	localparam logic [POS_W-1:0] CMT_LDSIZE_LO = 7'd1;
	localparam logic [POS_W-1:0] CMT_LDSIZE_HI = 7'd2;
	localparam logic [POS_W-1:0] CMT_LDFROM_LO = 7'd3;
	localparam logic [POS_W-1:0] CMT_LDFROM_HI = 7'd4;
	localparam logic [POS_W-1:0] CMT_OPCODE_LO = 7'd8;
	localparam logic [POS_W-1:0] CMT_OPCODE_HI = 7'd11;

	// leader period limits in 1/16 us
	localparam logic [15:0] PERIOD_DIRECT_LIMIT = 16'd1120;
	localparam logic [15:0] PERIOD_NORMAL_LIMIT = 16'd8000;
	localparam logic [15:0] PERIOD_ZX_LIMIT     = 16'd12800;

	// header field values
	localparam logic [7:0]  TYPE_FASTIPL     = 8'hBB;
	localparam logic [7:0]  TYPE_BSD         = 8'h04;
	localparam logic [7:0]  TYPE_CPM         = 8'h22;
	localparam logic [15:0] LOADER_EXEC      = 16'h1110;
	localparam logic [15:0] LOADER_START     = 16'h1200;
	localparam logic [15:0] PRELOAD_ADDR     = 16'hD400;
	localparam logic [15:0] BODY_FSK         = 16'd191;
	localparam logic [15:0] BODY_SLOW        = 16'd249;
	localparam logic [15:0] BODY_DIRECT      = 16'd360;
	localparam logic [15:0] PRELOAD_MAX_SIZE = 16'd500;
	localparam logic [15:0] BODY_TOLERANCE   = 16'd10;

	// seven-byte comment signature, first byte in the top byte
	localparam logic [55:0] SIG_PACKED = 56'h4E4950534F4654;

	// expected loader opcode bytes in comment bytes 8..11
	function automatic logic [7:0] opcode_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h3E;
			2'd1:    b = 8'h08;
			2'd2:    b = 8'hD3;
			default: b = 8'hCE;
		endcase
		return b;
	endfunction

	// preliminary format from the leader period
	function automatic fmt_t leader_class(input logic [15:0] p);
		fmt_t f;
		if (p < PERIOD_DIRECT_LIMIT) begin
			f = FMT_DIRECT;
		end else if (p < PERIOD_NORMAL_LIMIT) begin
			f = FMT_NORMAL;
		end else if (p < PERIOD_ZX_LIMIT) begin
			f = FMT_ZX;
		end else begin
			f = FMT_UNKNOWN;
		end
		return f;
	endfunction

endpackage

### hdl/tape_header_format_classifier.sv
// ----------------------------------------------------------------------------
// tape_header_format_classifier
// Sorts a tape into a format from its leader period and its header bytes.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_ready / item) carries either a leader
//   transaction (kind 0, leader_period) or one header byte (kind 1,
//   header_byte), header bytes in tape order starting at the type byte.
//   result channel (result_valid / result_ready / result) returns one
//   transaction per leader (preliminary format, from_header 0) and one per
//   complete header of 24 + COMMENT_BYTES bytes (final format, from_header 1).
//   Other header bytes give no result.
// Timing: a result is registered; an accepted transaction waits in the input
//   register, and its result is loaded into the result register when the
//   transaction advances, which a pending result can hold back.
// Throughput: one transaction per cycle unless stalled; the classification
//   is a single level of compares between the input and result registers.
// Reset: empties both registers and clears the header state; the header
//   position returns to the type byte and the preliminary format to unknown.
// Stall: a pending result holds in the result register; transactions that
//   give no result keep moving past it, and one that gives a result waits in
//   the input register, so item_ready drops only when both are full.
// ----------------------------------------------------------------------------
module tape_header_format_classifier #(
	parameter int unsigned COMMENT_BYTES = thfc_pkg::COMMENT_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  thfc_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output thfc_pkg::result_t result
);
	import thfc_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    has_result;
	result_t core_result;
	logic    result_valid_q;
	result_t result_q;

	// classification core with the header state
	thfc_core #(
		.COMMENT_BYTES(COMMENT_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (advance),
		.item      (item_s1),
		.has_result(has_result),
		.result    (core_result)
	);

	// staged transaction moves on unless its result has nowhere to go
	assign advance    = valid_s1 && (!has_result || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_q <= core_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a leader transaction always yields a leader result next cycle
	a_leader_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.kind == KIND_LEADER |=> result_valid && !result.from_header)
		else $error("leader transaction did not produce a leader result");

	// leader results only carry speed-class formats
	a_leader_format: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.from_header |->
		result.tape_format == FMT_UNKNOWN || result.tape_format == FMT_DIRECT ||
		result.tape_format == FMT_NORMAL || result.tape_format == FMT_ZX)
		else $error("leader result with a header-only format");

	// back-pressure only when both stages hold work
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1 && has_result && result_valid_q && !result_ready)
		else $error("item_ready low without a full pipeline");

	// a stalled result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready |-> !(advance && has_result))
		else $error("pending result overwritten");

endmodule

### hdl/thfc_core.sv
// ----------------------------------------------------------------------------
// thfc_core
// Header parsing state and classification logic. Computes the result of the
// staged transaction combinationally and updates the header state on take.
// ----------------------------------------------------------------------------
module thfc_core #(
	parameter int unsigned COMMENT_BYTES = thfc_pkg::COMMENT_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  thfc_pkg::item_t   item,
	output logic              has_result,
	output thfc_pkg::result_t result
);
	import thfc_pkg::*;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(POS_COMMENT + COMMENT_BYTES - 1);

	logic [POS_W-1:0] pos_q, pos_d;
	fmt_t             prelim_q, prelim_d;
	logic [7:0]       type_q, type_d;
	logic [15:0]      size_q, size_d;
	logic [15:0]      start_q, start_d;
	logic [15:0]      exec_q, exec_d;
	logic [15:0]      ldsize_q, ldsize_d;
	logic [15:0]      ldfrom_q, ldfrom_d;
	logic [47:0]      window_q, window_d;
	logic             sig_q, sig_d;
	logic             opok_q, opok_d;
	logic [55:0]      seq;
	logic [POS_W-1:0] cmt;
	fmt_t             leader_fmt;

	function automatic logic near(input logic [15:0] v, input logic [15:0] centre);
		return (v >= centre - BODY_TOLERANCE) && (v <= centre + BODY_TOLERANCE);
	endfunction

	// final format, first match in priority order wins
	function automatic fmt_t final_class(
		input logic [7:0]  t,
		input logic [15:0] sz,
		input logic [15:0] st,
		input logic [15:0] ex,
		input logic [15:0] lsz,
		input logic [15:0] lfr,
		input logic        sig,
		input logic        opok,
		input fmt_t        prelim
	);
		fmt_t f;
		if (t == TYPE_FASTIPL) begin
			f = FMT_FASTIPL;
		end else if (sig) begin
			f = FMT_TURBO;
		end else if (sz == 16'd0 && ex == LOADER_EXEC && st == LOADER_START && opok) begin
			if (lfr == PRELOAD_ADDR && lsz == BODY_FSK) begin
				f = FMT_FSK;
			end else if (lfr == PRELOAD_ADDR && lsz == BODY_SLOW) begin
				f = FMT_SLOW;
			end else if (lfr == PRELOAD_ADDR && lsz == BODY_DIRECT) begin
				f = FMT_DIRECT;
			end else begin
				f = FMT_TURBO;
			end
		end else if (st == PRELOAD_ADDR && ex == PRELOAD_ADDR && sz != 16'd0 &&
			sz <= PRELOAD_MAX_SIZE) begin
			if (near(sz, BODY_DIRECT)) begin
				f = FMT_DIRECT;
			end else if (near(sz, BODY_SLOW)) begin
				f = FMT_SLOW;
			end else if (near(sz, BODY_FSK)) begin
				f = FMT_FSK;
			end else begin
				f = FMT_TURBO;
			end
		end else if (t == TYPE_BSD && sz == 16'd0 && st == 16'd0 && ex == 16'd0) begin
			f = FMT_BSD;
		end else if (t == TYPE_CPM) begin
			f = FMT_CPM;
		end else begin
			f = prelim;
		end
		return f;
	endfunction

	// comment shift sequence and offset
	assign seq        = {window_q, item.header_byte};
	assign cmt        = pos_q - POS_COMMENT;
	assign leader_fmt = leader_class(item.leader_period);

	// next header state and result of the staged transaction
	always_comb begin
		pos_d      = pos_q;
		prelim_d   = prelim_q;
		type_d     = type_q;
		size_d     = size_q;
		start_d    = start_q;
		exec_d     = exec_q;
		ldsize_d   = ldsize_q;
		ldfrom_d   = ldfrom_q;
		window_d   = window_q;
		sig_d      = sig_q;
		opok_d     = opok_q;
		has_result = 1'b0;
		result     = '{tape_format: FMT_UNKNOWN, from_header: 1'b0};
		if (item.kind == KIND_LEADER) begin
			prelim_d   = leader_fmt;
			pos_d      = POS_TYPE;
			has_result = 1'b1;
			result     = '{tape_format: leader_fmt, from_header: 1'b0};
		end else begin
			if (pos_q == POS_TYPE) begin
				type_d   = item.header_byte;
				size_d   = '0;
				start_d  = '0;
				exec_d   = '0;
				ldsize_d = '0;
				ldfrom_d = '0;
				window_d = '0;
				sig_d    = 1'b0;
				opok_d   = 1'b1;
			end else if (pos_q == POS_SIZE_LO) begin
				size_d[7:0] = item.header_byte;
			end else if (pos_q == POS_SIZE_HI) begin
				size_d[15:8] = item.header_byte;
			end else if (pos_q == POS_START_LO) begin
				start_d[7:0] = item.header_byte;
			end else if (pos_q == POS_START_HI) begin
				start_d[15:8] = item.header_byte;
			end else if (pos_q == POS_EXEC_LO) begin
				exec_d[7:0] = item.header_byte;
			end else if (pos_q == POS_EXEC_HI) begin
				exec_d[15:8] = item.header_byte;
			end else if (pos_q >= POS_COMMENT && pos_q <= POS_LAST) begin
				if (seq == SIG_PACKED) begin
					sig_d = 1'b1;
				end
				window_d = seq[47:0];
				if (cmt == CMT_LDSIZE_LO) begin
					ldsize_d[7:0] = item.header_byte;
				end else if (cmt == CMT_LDSIZE_HI) begin
					ldsize_d[15:8] = item.header_byte;
				end else if (cmt == CMT_LDFROM_LO) begin
					ldfrom_d[7:0] = item.header_byte;
				end else if (cmt == CMT_LDFROM_HI) begin
					ldfrom_d[15:8] = item.header_byte;
				end else if (cmt >= CMT_OPCODE_LO && cmt <= CMT_OPCODE_HI &&
					item.header_byte != opcode_byte(cmt[1:0])) begin
					opok_d = 1'b0;
				end
			end
			// last header byte closes the header
			if (pos_q >= POS_LAST) begin
				pos_d      = POS_TYPE;
				has_result = 1'b1;
				result     = '{tape_format: final_class(type_d, size_d, start_d, exec_d,
					ldsize_d, ldfrom_d, sig_d, opok_d, prelim_q), from_header: 1'b1};
			end else begin
				pos_d = pos_q + 1'b1;
			end
		end
	end

	// header state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_TYPE;
			prelim_q <= FMT_UNKNOWN;
			type_q   <= '0;
			size_q   <= '0;
			start_q  <= '0;
			exec_q   <= '0;
			ldsize_q <= '0;
			ldfrom_q <= '0;
			window_q <= '0;
			sig_q    <= 1'b0;
			opok_q   <= 1'b1;
		end else if (take) begin
			pos_q    <= pos_d;
			prelim_q <= prelim_d;
			type_q   <= type_d;
			size_q   <= size_d;
			start_q  <= start_d;
			exec_q   <= exec_d;
			ldsize_q <= ldsize_d;
			ldfrom_q <= ldfrom_d;
			window_q <= window_d;
			sig_q    <= sig_d;
			opok_q   <= opok_d;
		end
	end

endmodule

### verif/tape_header_format_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_header_format_classifier_test
// Self-checking testbench: a directed table of leader periods, complete
// headers and a cut-off header, then random leader/header sequences, with
// random idling on both channels and one long result back-pressure. Results
// are checked against a local model of the classifier or the table's format.
// ----------------------------------------------------------------------------
module tape_header_format_classifier_test;
	import thfc_pkg::*;

	localparam int HDR_LEN = 24 + COMMENT_BYTES_DEF;
	localparam int HDR_LAST = HDR_LEN - 1;
	localparam int TOTAL_ITEMS = 1550;
	localparam int QUIET_TAIL = 300;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	// loader opcode bytes, first byte on top
	localparam logic [31:0] LOADER_OPC = 32'h3E08D3CE;

	typedef enum {ROW_LEADER, ROW_HEADER, ROW_PARTIAL} row_op_e;
	typedef enum {CMT_PLAIN, CMT_SIGNATURE, CMT_LOADER, CMT_LOADER_BADOP} cmt_e;

	// one directed row: a leader, a complete header, or a cut-off header
	typedef struct {
		row_op_e     op;
		logic [15:0] period;
		logic [7:0]  fill;
		logic [7:0]  htype;
		logic [15:0] size;
		logic [15:0] start;
		logic [15:0] exec;
		cmt_e        cmt;
		logic [15:0] ld_size;
		bit          typed;
		fmt_t        want;
	} dir_row_t;

	typedef struct {
		item_t it;
		bit    typed;
		fmt_t  want;
	} stim_t;

	localparam int NUM_ROWS = 19;
	dir_row_t dir_rows [NUM_ROWS] = '{
		'{ROW_HEADER, 0, 8'h00, 8'h01, 0, 0, 0, CMT_PLAIN, 0, 1, FMT_UNKNOWN},
		'{ROW_LEADER, 0, 0, 0, 0, 0, 0, CMT_PLAIN, 0, 1, FMT_DIRECT},
		'{ROW_LEADER, 1119, 0, 0, 0, 0, 0, CMT_PLAIN, 0, 1, FMT_DIRECT},
		'{ROW_LEADER, 1120, 0, 0, 0, 0, 0, CMT_PLAIN, 0, 1, FMT_NORMAL},
		'{ROW_LEADER, 7999, 0, 0, 0, 0, 0, CMT_PLAIN, 0, 1, FMT_NORMAL},
		'{ROW_LEADER, 8000, 0, 0, 0, 0, 0, CMT_PLAIN, 0, 1, FMT_ZX},
		'{ROW_LEADER, 12799, 0, 0, 0, 0, 0, CMT_PLAIN, 0, 1, FMT_ZX},
		'{ROW_LEADER, 12800, 0, 0, 0, 0, 0, CMT_PLAIN, 0, 1, FMT_UNKNOWN},
		'{ROW_LEADER, 65535, 0, 0, 0, 0, 0, CMT_PLAIN, 0, 1, FMT_UNKNOWN},
		'{ROW_LEADER, 2000, 0, 0, 0, 0, 0, CMT_PLAIN, 0, 1, FMT_NORMAL},
		'{ROW_HEADER, 0, 8'hFF, TYPE_FASTIPL, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			CMT_PLAIN, 0, 1, FMT_FASTIPL},
		'{ROW_HEADER, 0, 8'h00, 8'h01, 0, 0, 0, CMT_SIGNATURE, 0, 1, FMT_TURBO},
		'{ROW_HEADER, 0, 8'h00, 8'h01, 0, LOADER_START, LOADER_EXEC,
			CMT_LOADER, BODY_FSK, 1, FMT_FSK},
		'{ROW_HEADER, 0, 8'h00, 8'h01, 350, PRELOAD_ADDR, PRELOAD_ADDR,
			CMT_PLAIN, 0, 1, FMT_DIRECT},
		'{ROW_HEADER, 0, 8'h00, 8'h01, 259, PRELOAD_ADDR, PRELOAD_ADDR,
			CMT_PLAIN, 0, 1, FMT_SLOW},
		'{ROW_HEADER, 0, 8'h00, TYPE_BSD, 0, 0, 0, CMT_PLAIN, 0, 1, FMT_BSD},
		'{ROW_HEADER, 0, 8'h00, TYPE_CPM, 0, 0, 0, CMT_PLAIN, 0, 1, FMT_CPM},
		'{ROW_PARTIAL, 40, 8'h5A, 8'h01, 0, 0, 0, CMT_PLAIN, 0, 0, FMT_UNKNOWN},
		'{ROW_LEADER, 10000, 0, 0, 0, 0, 0, CMT_PLAIN, 0, 1, FMT_ZX}
	};

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	stim_t     stim_q [$];
	result_t   pending_formats [$];
	logic [7:0] hdr_buf [HDR_LEN];
	int        n_errors = 0;
	int        n_accepted = 0;
	int        n_checked = 0;
	int        n_leader_items = 0;
	int        n_header_items = 0;
	int        n_gen_results = 0;
	int        n_gen_headers = 0;
	int        dir_items = 0;
	int        quiet_cycles = 0;
	bit        stim_sent = 0;
	bit [15:0] formats_seen = '0;

	// classifier state as the testbench sees it
	int          hdr_pos;
	fmt_t        prelim_fmt;
	logic [7:0]  hdr_type;
	logic [15:0] hdr_size;
	logic [15:0] hdr_start;
	logic [15:0] hdr_exec;
	logic [15:0] ld_size;
	logic [15:0] ld_from;
	logic [47:0] cmt_window;
	bit          sig_found;
	bit          opc_ok;

	tape_header_format_classifier #(
		.COMMENT_BYTES(COMMENT_BYTES_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("[%0t] MISMATCH %s", $time, msg);
		n_errors++;
	endtask

	function automatic bit near_body(input logic [15:0] v, input logic [15:0] centre);
		return (v >= centre - BODY_TOLERANCE) && (v <= centre + BODY_TOLERANCE);
	endfunction

	// final format of a complete header, first matching rule wins
	function automatic fmt_t header_verdict();
		if (hdr_type == TYPE_FASTIPL)
			return FMT_FASTIPL;
		if (sig_found)
			return FMT_TURBO;
		if (hdr_size == 16'd0 && hdr_exec == LOADER_EXEC && hdr_start == LOADER_START
				&& opc_ok) begin
			if (ld_from == PRELOAD_ADDR) begin
				if (ld_size == BODY_FSK) return FMT_FSK;
				if (ld_size == BODY_SLOW) return FMT_SLOW;
				if (ld_size == BODY_DIRECT) return FMT_DIRECT;
			end
			return FMT_TURBO;
		end
		if (hdr_start == PRELOAD_ADDR && hdr_exec == PRELOAD_ADDR && hdr_size != 16'd0
				&& hdr_size <= PRELOAD_MAX_SIZE) begin
			if (near_body(hdr_size, BODY_DIRECT)) return FMT_DIRECT;
			if (near_body(hdr_size, BODY_SLOW)) return FMT_SLOW;
			if (near_body(hdr_size, BODY_FSK)) return FMT_FSK;
			return FMT_TURBO;
		end
		if (hdr_type == TYPE_BSD && hdr_size == 16'd0 && hdr_start == 16'd0
				&& hdr_exec == 16'd0)
			return FMT_BSD;
		if (hdr_type == TYPE_CPM)
			return FMT_CPM;
		return prelim_fmt;
	endfunction

	// advance the classifier state by one accepted transaction
	task automatic predict_format(input item_t it, output bit emits, output result_t res);
		logic [7:0]  b;
		logic [55:0] seq;
		int          c;
		emits = 1'b0;
		res = '0;
		if (it.kind == KIND_LEADER) begin
			if (it.leader_period < PERIOD_DIRECT_LIMIT)
				prelim_fmt = FMT_DIRECT;
			else if (it.leader_period < PERIOD_NORMAL_LIMIT)
				prelim_fmt = FMT_NORMAL;
			else if (it.leader_period < PERIOD_ZX_LIMIT)
				prelim_fmt = FMT_ZX;
			else
				prelim_fmt = FMT_UNKNOWN;
			hdr_pos = 0;
			emits = 1'b1;
			res.tape_format = prelim_fmt;
			res.from_header = 1'b0;
		end else begin
			b = it.header_byte;
			if (hdr_pos == POS_TYPE) begin
				hdr_type = b;
				hdr_size = '0;
				hdr_start = '0;
				hdr_exec = '0;
				ld_size = '0;
				ld_from = '0;
				cmt_window = '0;
				sig_found = 1'b0;
				opc_ok = 1'b1;
			end else if (hdr_pos == POS_SIZE_LO) begin
				hdr_size[7:0] = b;
			end else if (hdr_pos == POS_SIZE_HI) begin
				hdr_size[15:8] = b;
			end else if (hdr_pos == POS_START_LO) begin
				hdr_start[7:0] = b;
			end else if (hdr_pos == POS_START_HI) begin
				hdr_start[15:8] = b;
			end else if (hdr_pos == POS_EXEC_LO) begin
				hdr_exec[7:0] = b;
			end else if (hdr_pos == POS_EXEC_HI) begin
				hdr_exec[15:8] = b;
			end else if (hdr_pos >= POS_COMMENT && hdr_pos <= HDR_LAST) begin
				// comment: sliding signature window and loader fields
				c = hdr_pos - POS_COMMENT;
				seq = {cmt_window, b};
				if (seq == SIG_PACKED)
					sig_found = 1'b1;
				cmt_window = seq[47:0];
				if (c == CMT_LDSIZE_LO)
					ld_size[7:0] = b;
				else if (c == CMT_LDSIZE_HI)
					ld_size[15:8] = b;
				else if (c == CMT_LDFROM_LO)
					ld_from[7:0] = b;
				else if (c == CMT_LDFROM_HI)
					ld_from[15:8] = b;
				else if (c >= CMT_OPCODE_LO && c <= CMT_OPCODE_HI
						&& b != LOADER_OPC[31 - 8 * (c - CMT_OPCODE_LO) -: 8])
					opc_ok = 1'b0;
			end
			if (hdr_pos >= HDR_LAST) begin
				hdr_pos = 0;
				emits = 1'b1;
				res.tape_format = header_verdict();
				res.from_header = 1'b1;
			end else begin
				hdr_pos++;
			end
		end
	endtask

	// stimulus building
	task automatic push_leader(input logic [15:0] p, input bit typed, input fmt_t want);
		stim_t s;
		s.it.kind = KIND_LEADER;
		s.it.leader_period = p;
		s.it.header_byte = 8'($urandom);
		s.typed = typed;
		s.want = want;
		stim_q.push_back(s);
		n_gen_results++;
	endtask

	task automatic push_header(input int n, input bit typed, input fmt_t want);
		stim_t s;
		for (int k = 0; k < n; k++) begin
			s.it.kind = KIND_HEADER;
			s.it.leader_period = 16'($urandom);
			s.it.header_byte = hdr_buf[k];
			s.typed = typed && (k == HDR_LAST);
			s.want = want;
			stim_q.push_back(s);
		end
		if (n == HDR_LEN) begin
			n_gen_results++;
			n_gen_headers++;
		end
	endtask

	task automatic set_fields(input logic [7:0] t, input logic [15:0] sz,
			input logic [15:0] st, input logic [15:0] ex);
		hdr_buf[POS_TYPE] = t;
		hdr_buf[POS_SIZE_LO] = sz[7:0];
		hdr_buf[POS_SIZE_HI] = sz[15:8];
		hdr_buf[POS_START_LO] = st[7:0];
		hdr_buf[POS_START_HI] = st[15:8];
		hdr_buf[POS_EXEC_LO] = ex[7:0];
		hdr_buf[POS_EXEC_HI] = ex[15:8];
	endtask

	task automatic put_signature(input int off);
		for (int k = 0; k < 7; k++)
			hdr_buf[POS_COMMENT + off + k] = SIG_PACKED[55 - 8 * k -: 8];
	endtask

	// loader block in the comment: body size, load address, opcode bytes
	task automatic put_loader(input logic [15:0] body, input logic [15:0] from_addr);
		hdr_buf[POS_COMMENT + CMT_LDSIZE_LO] = body[7:0];
		hdr_buf[POS_COMMENT + CMT_LDSIZE_HI] = body[15:8];
		hdr_buf[POS_COMMENT + CMT_LDFROM_LO] = from_addr[7:0];
		hdr_buf[POS_COMMENT + CMT_LDFROM_HI] = from_addr[15:8];
		for (int k = 0; k < 4; k++)
			hdr_buf[POS_COMMENT + CMT_OPCODE_LO + k] = LOADER_OPC[31 - 8 * k -: 8];
	endtask

	// leader periods cluster around the speed thresholds, with extremes and random values
	function automatic logic [15:0] pick_period();
		case ($urandom_range(0, 5))
			0: return PERIOD_DIRECT_LIMIT - 16'd2 + 16'($urandom_range(0, 4));
			1: return PERIOD_NORMAL_LIMIT - 16'd2 + 16'($urandom_range(0, 4));
			2: return PERIOD_ZX_LIMIT - 16'd2 + 16'($urandom_range(0, 4));
			3: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
			4: return 16'($urandom_range(0, 13000));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_body();
		case ($urandom_range(0, 5))
			0: return BODY_FSK;
			1: return BODY_SLOW;
			2: return BODY_DIRECT;
			3: return BODY_FSK + 16'd1;
			4: return BODY_DIRECT - 16'd1;
			default: return 16'($urandom_range(0, 600));
		endcase
	endfunction

	// sizes near the body windows and the preload size limit, plus random sizes
	function automatic logic [15:0] pick_preload_size();
		logic [15:0] centre;
		case ($urandom_range(0, 2))
			0: centre = BODY_FSK;
			1: centre = BODY_SLOW;
			default: centre = BODY_DIRECT;
		endcase
		case ($urandom_range(0, 4))
			0, 1: return centre - 16'd12 + 16'($urandom_range(0, 24));
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'd0;
					1: return 16'd1;
					2: return PRELOAD_MAX_SIZE;
					default: return PRELOAD_MAX_SIZE + 16'd1;
				endcase
			end
			3: return 16'($urandom_range(1, 500));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return LOADER_EXEC;
			2: return LOADER_START;
			3: return PRELOAD_ADDR;
			default: return 16'($urandom);
		endcase
	endfunction

	// random header content steered toward each classification rule
	task automatic make_random_header();
		int          off;
		logic [7:0]  t;
		for (int k = 0; k < HDR_LEN; k++)
			hdr_buf[k] = 8'($urandom);
		case ($urandom_range(0, 7))
			0: ;
			1: hdr_buf[POS_TYPE] = TYPE_FASTIPL;
			2: begin
				off = $urandom_range(0, COMMENT_BYTES_DEF - 7);
				put_signature(off);
				// near miss: one flipped bit
				if ($urandom_range(0, 3) == 0)
					hdr_buf[POS_COMMENT + off + $urandom_range(0, 6)] ^=
						8'h01 << $urandom_range(0, 7);
			end
			3: begin
				set_fields(8'($urandom), 16'd0, LOADER_START, LOADER_EXEC);
				put_loader(pick_body(),
					($urandom_range(0, 7) == 0) ? 16'($urandom) : PRELOAD_ADDR);
				if ($urandom_range(0, 5) == 0)
					hdr_buf[POS_COMMENT + CMT_OPCODE_LO + $urandom_range(0, 3)] ^=
						8'h01 << $urandom_range(0, 7);
			end
			4: set_fields(8'($urandom), pick_preload_size(), PRELOAD_ADDR, PRELOAD_ADDR);
			5: begin
				set_fields(TYPE_BSD, 16'd0, 16'd0, 16'd0);
				if ($urandom_range(0, 3) == 0)
					hdr_buf[POS_SIZE_LO + $urandom_range(0, 5)] = 8'($urandom_range(1, 255));
			end
			6: hdr_buf[POS_TYPE] = TYPE_CPM;
			default: begin
				case ($urandom_range(0, 2))
					0: t = TYPE_BSD;
					1: t = TYPE_CPM;
					default: t = 8'($urandom);
				endcase
				set_fields(t, pick_word(), pick_word(), pick_word());
			end
		endcase
	endtask

	task automatic build_stimulus();
		int r;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].op == ROW_LEADER) begin
				push_leader(dir_rows[i].period, dir_rows[i].typed, dir_rows[i].want);
			end else begin
				for (int k = 0; k < HDR_LEN; k++)
					hdr_buf[k] = dir_rows[i].fill;
				set_fields(dir_rows[i].htype, dir_rows[i].size, dir_rows[i].start,
					dir_rows[i].exec);
				if (dir_rows[i].cmt == CMT_SIGNATURE) begin
					// signature ending on the last comment byte
					put_signature(COMMENT_BYTES_DEF - 7);
				end else if (dir_rows[i].cmt != CMT_PLAIN) begin
					put_loader(dir_rows[i].ld_size, PRELOAD_ADDR);
					if (dir_rows[i].cmt == CMT_LOADER_BADOP)
						hdr_buf[POS_COMMENT + CMT_OPCODE_LO + 2] = 8'h00;
				end
				push_header((dir_rows[i].op == ROW_PARTIAL) ? int'(dir_rows[i].period) :
					HDR_LEN, dir_rows[i].typed, dir_rows[i].want);
			end
		end
		dir_items = stim_q.size();

		// random leader/header sequences, some cut off by a new leader
		while (stim_q.size() < TOTAL_ITEMS || n_gen_results < 24
				|| n_gen_headers < 10) begin
			push_leader(pick_period(), 1'b0, FMT_UNKNOWN);
			if ($urandom_range(0, 4) == 0)
				push_leader(pick_period(), 1'b0, FMT_UNKNOWN);
			r = $urandom_range(0, 9);
			make_random_header();
			if (r == 0) begin
				push_header($urandom_range(1, HDR_LAST), 1'b0, FMT_UNKNOWN);
			end else begin
				push_header(HDR_LEN, 1'b0, FMT_UNKNOWN);
				// back-to-back header after the position wraps
				if (r == 1) begin
					make_random_header();
					push_header(HDR_LEN, 1'b0, FMT_UNKNOWN);
				end
			end
		end
	endtask

	// checker: results against expectations, accepted items into the model
	always @(posedge clk) begin : scoreboard
		bit      emits;
		result_t pred;
		result_t want;
		if (arst_n) begin
			if ((result_valid && result_ready) || (item_valid && item_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (result_valid && result_ready) begin
				if (pending_formats.size() == 0) begin
					report_error($sformatf("result format %0d from_header %0b with none expected",
						result.tape_format, result.from_header));
				end else begin
					want = pending_formats.pop_front();
					n_checked++;
					if (result.tape_format !== want.tape_format)
						report_error($sformatf("tape_format got %0d want %0d",
							result.tape_format, want.tape_format));
					if (result.from_header !== want.from_header)
						report_error($sformatf("from_header got %0b want %0b",
							result.from_header, want.from_header));
					if (want.from_header)
						formats_seen[want.tape_format] = 1'b1;
				end
			end
			if (item_valid && item_ready) begin
				predict_format(item, emits, pred);
				if (emits) begin
					if (stim_q[n_accepted].typed)
						pred.tape_format = stim_q[n_accepted].want;
					pending_formats.push_back(pred);
				end
				if (item.kind == KIND_LEADER)
					n_leader_items++;
				else
					n_header_items++;
				n_accepted++;
			end
		end
	end

	// item sender
	initial begin : sender
		bit idle_ok;
		item_valid = 1'b0;
		item = '0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		for (int i = 0; i < stim_q.size(); i++) begin
			idle_ok = (i < stim_q.size() - QUIET_TAIL) && ((i / 300) % 3 != 2);
			if (idle_ok && $urandom_range(0, 9) == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			item_valid <= 1'b1;
			item <= stim_q[i].it;
			do @(posedge clk); while (item_ready !== 1'b1);
			@(negedge clk);
		end
		item_valid <= 1'b0;
		stim_sent = 1'b1;
	end

	// result receiver, with one long hold-off as the directed leaders arrive
	initial begin : receiver
		bit idle_ok;
		bit held_off;
		int hold;
		held_off = 1'b0;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			idle_ok = (n_accepted < stim_q.size() - QUIET_TAIL) && ((n_accepted / 256) % 4 != 3);
			if (!held_off && n_accepted >= HDR_LEN) begin
				result_ready <= 1'b0;
				hold = HOLD_OFF_CYCLES;
				held_off = 1'b1;
			end else if (idle_ok && $urandom_range(0, 4) == 0) begin
				result_ready <= 1'b0;
				hold = $urandom_range(1, 12);
			end else begin
				result_ready <= 1'b1;
				hold = 1;
			end
			repeat (hold) @(negedge clk);
		end
	end

	// watchdog on cycles with no transaction on either channel
	initial begin : watchdog
		do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
		$display("Timeout after %0d cycles without a transaction", WATCHDOG_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// reset, run, drain and verdict
	initial begin : main
		arst_n = 1'b0;
		hdr_pos = 0;
		prelim_fmt = FMT_UNKNOWN;
		hdr_type = '0;
		hdr_size = '0;
		hdr_start = '0;
		hdr_exec = '0;
		ld_size = '0;
		ld_from = '0;
		cmt_window = '0;
		sig_found = 1'b0;
		opc_ok = 1'b1;
		build_stimulus();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (stim_sent);
		while (pending_formats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d leader and %0d header byte transactions, %0d results checked",
			n_leader_items, n_header_items, n_checked);
		$display("Complete headers reached %0d of the 10 format codes", $countones(formats_seen));
		if (n_errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
